// ----- rtl/kmer_count_table_defines.svh -----
// Assertion macros for the k-mer count table.
// Included by files that carry concurrent checks; needs clk and rst in scope.
`ifndef KMER_COUNT_TABLE_DEFINES_SVH
`define KMER_COUNT_TABLE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define KCT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kct: same-cycle check failed");
`define KCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kct: next-cycle check failed");
`else
`define KCT_ASSERT_IMPL(lbl, ante, cons)
`define KCT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/kct_pkg.sv -----
// Shared types and constants for the k-mer count table.
// No dependencies; the files that use it refer to it by scoped names.
package kct_pkg;

  localparam int CMD_W  = 2;
  localparam int BASE_W = 2;
  localparam int KIDX_W = 16;
  localparam int BIN_W  = 8;
  localparam int VAL_W  = 17;
  localparam int KLEN_W = 4;

  localparam logic [KLEN_W-1:0] KLEN_RESET = 4'd8;

  localparam int DEF_MAX_K     = 8;
  localparam int DEF_COUNT_MAX = 255;

  typedef enum logic [CMD_W-1:0] {
    CMD_COUNT = 2'd0,
    CMD_QCNT  = 2'd1,
    CMD_QBIN  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_FETCH,
    ST_INC,
    ST_DEC,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic lookup;
    logic fetch;
    logic inc;
    logic dec;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic upd;
    logic c_nz;
  } dp_stat_t;

endpackage

// ----- rtl/kct_req_if.sv -----
// Request channel: one command with its base or query address.
// Depends on kct_pkg for field widths.
interface kct_req_if;
  logic                          valid;
  logic                          ready;
  logic [kct_pkg::CMD_W-1:0]     command;
  logic [kct_pkg::BASE_W-1:0]    base;
  logic                          read_start;
  logic [kct_pkg::KIDX_W-1:0]    kmer_index;
  logic [kct_pkg::BIN_W-1:0]     bin_index;

  modport source (output valid, command, base, read_start, kmer_index, bin_index,
                  input ready);
  modport sink (input valid, command, base, read_start, kmer_index, bin_index,
                output ready);
endinterface

// ----- rtl/kct_rsp_if.sv -----
// Response channel: one result per accepted request.
// Depends on kct_pkg for field widths.
interface kct_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [kct_pkg::VAL_W-1:0]  value;
  logic                       counted;
  logic [kct_pkg::VAL_W-1:0]  mid_total;

  modport source (output valid, value, counted, mid_total, input ready);
  modport sink (input valid, value, counted, mid_total, output ready);
endinterface

// ----- rtl/kct_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kct_ram #(
  parameter int WIDTH = 8,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/kct_dp.sv -----
// Datapath: rolling k-mer, count table, histogram, totals and result register.
// Depends on kct_pkg and kct_ram; driven by kct_ctrl commands.
module kct_dp #(
  parameter int MAX_K     = kct_pkg::DEF_MAX_K,
  parameter int COUNT_MAX = kct_pkg::DEF_COUNT_MAX
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [kct_pkg::KLEN_W-1:0]    cfg_wdata,
  input  logic [kct_pkg::CMD_W-1:0]     command,
  input  logic [kct_pkg::BASE_W-1:0]    base,
  input  logic                          read_start,
  input  logic [kct_pkg::KIDX_W-1:0]    kmer_index,
  input  logic [kct_pkg::BIN_W-1:0]     bin_index,
  input  kct_pkg::dp_cmd_t              cmd,
  output kct_pkg::dp_stat_t             stat,
  output logic [kct_pkg::VAL_W-1:0]     value,
  output logic                          counted,
  output logic [kct_pkg::VAL_W-1:0]     mid_total
);

  localparam int KW    = 2 * MAX_K;
  localparam int CW    = $clog2(COUNT_MAX + 1);
  localparam int TW    = KW + 1;
  localparam int FW    = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int EW    = 5;
  localparam int CLR_W = (KW > CW) ? KW : CW;
  localparam int VW    = kct_pkg::VAL_W;
  localparam logic [CW-1:0] CMAX = CW'(COUNT_MAX);

  // configuration and stream state
  logic [kct_pkg::KLEN_W-1:0] kmer_length;
  logic [KW-1:0]              rolling;
  logic [FW-1:0]              fill;
  logic [TW-1:0]              nonzero_total;
  logic [TW-1:0]              mid_count;
  logic [CLR_W-1:0]           clear_addr;

  // item under work
  logic [kct_pkg::CMD_W-1:0]  item_cmd;
  logic [kct_pkg::BIN_W-1:0]  item_bin;
  logic                       filling;
  logic [KW-1:0]              tab_addr;
  logic [CW-1:0]              cnt_c;
  logic [VW-1:0]              res_value;
  logic                       res_counted;

  logic [EW-1:0]              eff_k;
  logic [KW-1:0]              mask;
  logic [KW-1:0]              r_base;
  logic [KW-1:0]              r_new;
  logic [FW-1:0]              f_base;
  logic                       still_fill;

  logic                       twe;
  logic [KW-1:0]              twaddr;
  logic [CW-1:0]              twdata;
  logic [CW-1:0]              tab_q;
  logic                       hwe;
  logic [CW-1:0]              hwaddr;
  logic [TW-1:0]              hwdata;
  logic [CW-1:0]              hraddr;
  logic [TW-1:0]              hist_q;

  logic [CW-1:0]              c_inc;
  logic                       upd_now;
  logic                       mid_inc;
  logic                       mid_dec;
  logic [TW-1:0]              total;
  logic [TW-1:0]              bin0;
  logic [VW-1:0]              res_next;

  always_comb begin
    if (kmer_length == '0) begin
      eff_k = EW'(1);
    end else if (EW'(kmer_length) > EW'(MAX_K)) begin
      eff_k = EW'(MAX_K);
    end else begin
      eff_k = EW'(kmer_length);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_K; i++) begin
      mask[2*i +: 2] = (EW'(i) < eff_k) ? 2'b11 : 2'b00;
    end
  end

  assign r_base     = read_start ? '0 : rolling;
  assign f_base     = read_start ? '0 : fill;
  assign r_new      = KW'({r_base, base}) & mask;
  assign still_fill = EW'(f_base) < (eff_k - EW'(1));

  assign c_inc   = tab_q + CW'(1);
  assign upd_now = (item_cmd == kct_pkg::CMD_COUNT) && !filling && (tab_q < CMAX);
  assign mid_inc = (tab_q == '0) && (c_inc < CMAX);
  assign mid_dec = (tab_q != '0) && (c_inc == CMAX);

  assign total = TW'({1'b0, mask}) + TW'(1);
  assign bin0  = (total > nonzero_total) ? (total - nonzero_total) : '0;

  // table write port: clearing sweep or counter update
  always_comb begin
    if (cmd.clear) begin
      twe    = 1'b1;
      twaddr = KW'(clear_addr);
      twdata = '0;
    end else begin
      twe    = cmd.fetch && upd_now;
      twaddr = tab_addr;
      twdata = c_inc;
    end
  end

  // histogram ports: queried bin, then new bin, then old bin
  always_comb begin
    if (cmd.lookup) begin
      hraddr = CW'(item_bin);
    end else if (cmd.fetch) begin
      hraddr = c_inc;
    end else begin
      hraddr = cnt_c;
    end
  end

  always_comb begin
    hwe = cmd.clear || cmd.inc || cmd.dec;
    if (cmd.clear) begin
      hwaddr = CW'(clear_addr);
      hwdata = '0;
    end else if (cmd.inc) begin
      hwaddr = cnt_c + CW'(1);
      hwdata = hist_q + TW'(1);
    end else begin
      hwaddr = cnt_c;
      hwdata = hist_q - TW'(1);
    end
  end

  always_comb begin
    unique case (item_cmd)
      kct_pkg::CMD_COUNT: begin
        if (filling) begin
          res_next = '0;
        end else begin
          res_next = upd_now ? VW'(c_inc) : VW'(tab_q);
        end
      end
      kct_pkg::CMD_QCNT: res_next = VW'(tab_q);
      kct_pkg::CMD_QBIN: begin
        if (item_bin == '0) begin
          res_next = VW'(bin0);
        end else if (int'(item_bin) <= COUNT_MAX) begin
          res_next = VW'(hist_q);
        end else begin
          res_next = '0;
        end
      end
      default: res_next = '0;
    endcase
  end

  assign stat.clear_done = &clear_addr;
  assign stat.upd        = upd_now;
  assign stat.c_nz       = cnt_c != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length   <= kct_pkg::KLEN_RESET;
      rolling       <= '0;
      fill          <= '0;
      nonzero_total <= '0;
      mid_count     <= '0;
      clear_addr    <= '0;
    end else begin
      if (cfg_we) begin
        kmer_length <= cfg_wdata;
        rolling     <= '0;
        fill        <= '0;
      end else if (cmd.accept && command == kct_pkg::CMD_COUNT) begin
        rolling <= r_new;
        fill    <= still_fill ? (f_base + FW'(1)) : f_base;
      end
      if (cmd.clear) begin
        clear_addr <= clear_addr + CLR_W'(1);
      end
      if (cmd.fetch && upd_now) begin
        if (tab_q == '0) begin
          nonzero_total <= nonzero_total + TW'(1);
        end
        if (mid_inc) begin
          mid_count <= mid_count + TW'(1);
        end else if (mid_dec) begin
          mid_count <= mid_count - TW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_cmd <= command;
      item_bin <= bin_index;
      filling  <= still_fill;
      tab_addr <= (command == kct_pkg::CMD_COUNT) ? r_new : (KW'(kmer_index) & mask);
    end
    if (cmd.fetch) begin
      cnt_c       <= tab_q;
      res_value   <= res_next;
      res_counted <= (item_cmd == kct_pkg::CMD_COUNT) && !filling;
    end
    if (cmd.load_out) begin
      value     <= res_value;
      counted   <= res_counted;
      mid_total <= VW'(mid_count);
    end
  end

  kct_ram #(.WIDTH(CW), .AW(KW)) u_table (
    .clk   (clk),
    .we    (twe),
    .waddr (twaddr),
    .wdata (twdata),
    .raddr (tab_addr),
    .rdata (tab_q)
  );

  kct_ram #(.WIDTH(TW), .AW(CW)) u_hist (
    .clk   (clk),
    .we    (hwe),
    .waddr (hwaddr),
    .wdata (hwdata),
    .raddr (hraddr),
    .rdata (hist_q)
  );

endmodule

// ----- rtl/kct_ctrl.sv -----
// Controller: sequences clearing, lookup and read-modify-write of each item.
// Depends on kct_pkg and the assertion macros in kmer_count_table_defines.svh.
`include "kmer_count_table_defines.svh"

module kct_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  input  kct_pkg::dp_stat_t  stat,
  output kct_pkg::dp_cmd_t   cmd
);

  kct_pkg::state_t state;
  kct_pkg::state_t state_next;
  logic            out_vld;
  logic            out_vld_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= kct_pkg::ST_CLEAR;
      out_vld <= 1'b0;
    end else begin
      state   <= state_next;
      out_vld <= out_vld_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      kct_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_done) begin
          state_next = kct_pkg::ST_IDLE;
        end
      end
      kct_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = kct_pkg::ST_LOOKUP;
        end
      end
      kct_pkg::ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = kct_pkg::ST_FETCH;
      end
      kct_pkg::ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = stat.upd ? kct_pkg::ST_INC : kct_pkg::ST_RESULT;
      end
      kct_pkg::ST_INC: begin
        cmd.inc    = 1'b1;
        state_next = stat.c_nz ? kct_pkg::ST_DEC : kct_pkg::ST_RESULT;
      end
      kct_pkg::ST_DEC: begin
        cmd.dec    = 1'b1;
        state_next = kct_pkg::ST_RESULT;
      end
      kct_pkg::ST_RESULT: begin
        // hold until the output register is free or being drained
        if (!out_vld || rsp_ready) begin
          cmd.load_out = 1'b1;
          state_next   = kct_pkg::ST_IDLE;
        end
      end
      default: state_next = kct_pkg::ST_CLEAR;
    endcase
    out_vld_next = cmd.load_out || (out_vld && !rsp_ready);
  end

  assign rsp_valid = out_vld;

  `KCT_ASSERT_NEXT(a_accept_to_lookup, req_valid && req_ready, state == kct_pkg::ST_LOOKUP)
  `KCT_ASSERT_IMPL(a_no_overwrite, rsp_valid && !rsp_ready, !cmd.load_out)
  `KCT_ASSERT_IMPL(a_dec_after_inc, state == kct_pkg::ST_DEC, $past(state) == kct_pkg::ST_INC)
  `KCT_ASSERT_IMPL(a_clear_after_reset, $fell(rst), state == kct_pkg::ST_CLEAR)

endmodule

// ----- rtl/kmer_count_table.sv -----
// Top level of the k-mer count table: controller, datapath and their channels.
// Depends on kct_pkg, kct_req_if, kct_rsp_if, kct_ctrl and kct_dp.
// Usage:
//   req carries one command per transfer: count a base (with read_start marking
//   the first base of a read), read one k-mer counter, or read one histogram bin.
//   rsp returns exactly one result per request: value, counted and mid_total.
//   cfg_we/cfg_wdata write k (bases per k-mer); a write also restarts filling.
// Sequence:
//   An item runs IDLE, LOOKUP, FETCH, optional INC and DEC, RESULT: INC and DEC are
//   skipped for queries, filling bases and saturated counters, a first occurrence
//   adds INC only and a repeat adds both. A new request is taken only in IDLE,
//   after RESULT of the previous one. The histogram RAM has one write port, so the
//   new bin and the old bin are written in separate cycles after the counter read.
// Reset:
//   rst clears the control state, then a sweep over every address zeroes the count
//   table and the histogram, with req.ready low. Configuration writes are taken
//   during the sweep.
// Stall:
//   The output register holds a result while rsp.ready is low; the next request
//   is still accepted and processed, then waits in RESULT until the register is free.
module kmer_count_table #(
  parameter int MAX_K     = kct_pkg::DEF_MAX_K,
  parameter int COUNT_MAX = kct_pkg::DEF_COUNT_MAX
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [kct_pkg::KLEN_W-1:0]  cfg_wdata,
  kct_req_if.sink                     req,
  kct_rsp_if.source                   rsp
);

  kct_pkg::dp_cmd_t  cmd;
  kct_pkg::dp_stat_t stat;

  // sequence each transfer through the memory steps
  kct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // counters, histogram and result register
  kct_dp #(
    .MAX_K     (MAX_K),
    .COUNT_MAX (COUNT_MAX)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .command    (req.command),
    .base       (req.base),
    .read_start (req.read_start),
    .kmer_index (req.kmer_index),
    .bin_index  (req.bin_index),
    .cmd        (cmd),
    .stat       (stat),
    .value      (rsp.value),
    .counted    (rsp.counted),
    .mid_total  (rsp.mid_total)
  );

endmodule
